// ----- hdl/multi_servo_slew_limiter_assert.svh -----
// assertion macros shared by the checker files
`ifndef MULTI_SERVO_SLEW_LIMITER_ASSERT_SVH
`define MULTI_SERVO_SLEW_LIMITER_ASSERT_SVH

// clocked assertion with an active-low synchronous reset
`define MSL_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msl assertion failed");

// same, on the block's own clock and reset names
`define MSL_ASSERT(lbl, prop) `MSL_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ----- hdl/msl_pkg.sv -----
package msl_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_SERVOS_IN_USE    = 3'd0;
    localparam logic [2:0] CFG_MAX_STEP         = 3'd1;
    localparam logic [2:0] CFG_MOVE_HOLD        = 3'd2;
    localparam logic [2:0] CFG_REVERSE_HOLD     = 3'd3;
    localparam logic [2:0] CFG_RETARGET_HOLD    = 3'd4;

    // action codes
    localparam logic ACT_TICK       = 1'b0;
    localparam logic ACT_SET_TARGET = 1'b1;

    localparam logic [7:0]  ANGLE_MAX   = 8'd180;
    localparam logic [7:0]  HOLD_RESET  = 8'd10;
    localparam logic [11:0] PULSE_BASE  = 12'd400;
    // 80 * ceil(2^16 / 9): exact floor(80*a/9) for any 8-bit angle
    localparam logic [19:0] PULSE_RECIP = 20'd582560;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [7:0] angle;
        logic [7:0] target;
        logic [7:0] hold;
        t_dir       dir;
        logic       pending;
    } t_slot_state;

    typedef struct packed {
        logic [7:0] max_step;
        logic [7:0] move_hold;
        logic [7:0] reverse_hold;
        logic [7:0] retarget_hold;
    } t_move_cfg;

    localparam t_slot_state SLOT_RESET = '{
        angle:   8'd0,
        target:  8'd0,
        hold:    HOLD_RESET,
        dir:     DIR_NONE,
        pending: 1'b0
    };

endpackage

// ----- hdl/msl_slot_mem.sv -----
module msl_slot_mem #(
    parameter int SERVO_SLOTS = 8,
    localparam int IDX_W = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output msl_pkg::t_slot_state o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  msl_pkg::t_slot_state i_wr_data
);

    msl_pkg::t_slot_state r_mem [SERVO_SLOTS];
    logic [SERVO_SLOTS-1:0] r_valid;
    msl_pkg::t_slot_state   r_rd_data;

    // entries never written read back as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : msl_pkg::SLOT_RESET;
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/msl_slot_alu.sv -----
module msl_slot_alu (
    input  msl_pkg::t_slot_state i_cur,
    input  msl_pkg::t_move_cfg   i_cfg,
    output msl_pkg::t_slot_state o_nxt,
    output logic [10:0]          o_pulse_us,
    output logic                 o_at_rest
);

    logic        up;
    logic [7:0]  delta;
    msl_pkg::t_dir new_dir;
    logic [27:0] prod;
    logic [11:0] pulse_full;

    // pulse from the angle before the update
    assign prod       = 28'(i_cur.angle) * 28'(msl_pkg::PULSE_RECIP);
    assign pulse_full = msl_pkg::PULSE_BASE + prod[27:16];
    assign o_pulse_us = pulse_full[10:0];

    assign up      = i_cur.target > i_cur.angle;
    assign delta   = up ? (i_cur.target - i_cur.angle) : (i_cur.angle - i_cur.target);
    assign new_dir = up ? msl_pkg::DIR_UP : msl_pkg::DIR_DOWN;

    always_comb begin
        o_nxt = i_cur;
        if (i_cur.hold != 8'd0) begin
            o_nxt.hold = i_cur.hold - 8'd1;
        end else if (i_cur.pending && i_cfg.retarget_hold != 8'd0) begin
            o_nxt.hold    = i_cfg.retarget_hold;
            o_nxt.pending = 1'b0;
        end else if (i_cur.angle != i_cur.target) begin
            if (new_dir != i_cur.dir && i_cfg.reverse_hold != 8'd0) begin
                o_nxt.hold = i_cfg.reverse_hold;
            end else begin
                if (delta <= i_cfg.max_step) begin
                    o_nxt.angle = i_cur.target;
                end else if (up) begin
                    o_nxt.angle = i_cur.angle + i_cfg.max_step;
                end else begin
                    o_nxt.angle = i_cur.angle - i_cfg.max_step;
                end
                o_nxt.hold = i_cfg.move_hold;
            end
            o_nxt.dir = new_dir;
        end
    end

    assign o_at_rest = (o_nxt.hold == 8'd0) && (o_nxt.angle == o_nxt.target);

endmodule

// ----- hdl/multi_servo_slew_limiter.sv -----
// tick: busy while it walks the slots in use; each result strobe is registered from a slot's update
//   state and shows in the cycle after it, the last one in the cycle busy drops
// set target: busy through a read and an update state on a slot in use, no result; on a slot
//   not in use it is dropped without going busy, as is a tick with no slots in use
// the state memory's registered read port sets a read state and an update state per slot
// results are single-cycle strobes, the receiver cannot stall them
// synchronous active-low reset restores the state, config and valid flags and every slot's reset state
module multi_servo_slew_limiter #(
    parameter int SERVO_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_action,
    input  logic [2:0]  i_slot,
    input  logic [7:0]  i_target_angle,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // result beats
    output logic        o_valid,
    output logic [2:0]  o_servo_index,
    output logic [10:0] o_pulse_us,
    output logic [7:0]  o_angle_now,
    output logic        o_at_rest,
    output logic        o_last_of_tick
);

    localparam int IDX_W = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;
    localparam int CNT_W = $clog2(SERVO_SLOTS + 1);
    // common width for comparing a slot number against the slot count
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

    // configuration registers
    logic [3:0] r_servos_in_use;
    msl_pkg::t_move_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servos_in_use     <= 4'd1;
            r_cfg.max_step      <= 8'd1;
            r_cfg.move_hold     <= msl_pkg::HOLD_RESET;
            r_cfg.reverse_hold  <= 8'd0;
            r_cfg.retarget_hold <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                msl_pkg::CFG_SERVOS_IN_USE: r_servos_in_use     <= i_cfg_data[3:0];
                msl_pkg::CFG_MAX_STEP:      r_cfg.max_step      <= i_cfg_data;
                msl_pkg::CFG_MOVE_HOLD:     r_cfg.move_hold     <= i_cfg_data;
                msl_pkg::CFG_REVERSE_HOLD:  r_cfg.reverse_hold  <= i_cfg_data;
                msl_pkg::CFG_RETARGET_HOLD: r_cfg.retarget_hold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // slots actually walked: the register clipped to the slot count
    logic [CNT_W-1:0] n_slots;
    assign n_slots = (32'(r_servos_in_use) > SERVO_SLOTS) ? CNT_W'(SERVO_SLOTS)
                                                          : CNT_W'(r_servos_in_use);

    // sequencer
    msl_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_is_tick, n_is_tick;
    logic [7:0]       r_new_target, n_new_target;

    logic                 accept;
    logic                 slot_ok;
    logic                 last_slot;
    logic                 wr_en;
    msl_pkg::t_slot_state rd_data, wr_data, alu_nxt;
    logic [10:0]          alu_pulse;
    logic                 alu_at_rest;

    assign accept    = i_start && (r_state == msl_pkg::ST_IDLE);
    assign slot_ok   = CMP_W'(i_slot) < CMP_W'(n_slots);
    assign last_slot = (CNT_W'(r_idx) + CNT_W'(1)) == n_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_is_tick    <= n_is_tick;
        r_new_target <= n_new_target;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_is_tick    = r_is_tick;
        n_new_target = r_new_target;
        wr_en        = 1'b0;
        wr_data      = alu_nxt;
        unique case (r_state)
            msl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_is_tick    = (i_action == msl_pkg::ACT_TICK);
                    // saturate the target on the way in
                    n_new_target = (i_target_angle > msl_pkg::ANGLE_MAX) ? msl_pkg::ANGLE_MAX
                                                                         : i_target_angle;
                    if (i_action == msl_pkg::ACT_TICK) begin
                        n_idx = '0;
                        if (n_slots != '0) begin
                            n_state = msl_pkg::ST_READ;
                        end
                    end else begin
                        n_idx = IDX_W'(i_slot);
                        if (slot_ok) begin
                            n_state = msl_pkg::ST_READ;
                        end
                    end
                end
            end
            msl_pkg::ST_READ: begin
                // memory address is presented this cycle, data lands next cycle
                n_state = msl_pkg::ST_EXEC;
            end
            msl_pkg::ST_EXEC: begin
                wr_en = 1'b1;
                if (r_is_tick) begin
                    wr_data = alu_nxt;
                    if (last_slot) begin
                        n_state = msl_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = msl_pkg::ST_READ;
                    end
                end else begin
                    // set target: read-modify-write of one slot
                    wr_data         = rd_data;
                    wr_data.target  = r_new_target;
                    wr_data.pending = 1'b1;
                    n_state         = msl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = msl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != msl_pkg::ST_IDLE);

    // per-slot state store
    msl_slot_mem #(
        .SERVO_SLOTS(SERVO_SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_data)
    );

    // shared update and pulse unit, used once per slot
    msl_slot_alu u_alu (
        .i_cur      (rd_data),
        .i_cfg      (r_cfg),
        .o_nxt      (alu_nxt),
        .o_pulse_us (alu_pulse),
        .o_at_rest  (alu_at_rest)
    );

    // result beat register
    logic        r_valid;
    logic [2:0]  r_servo_index;
    logic [10:0] r_pulse_us;
    logic [7:0]  r_angle_now;
    logic        r_at_rest;
    logic        r_last_of_tick;
    logic        emit;

    assign emit = (r_state == msl_pkg::ST_EXEC) && r_is_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_servo_index  <= 3'(r_idx);
            r_pulse_us     <= alu_pulse;
            r_angle_now    <= alu_nxt.angle;
            r_at_rest      <= alu_at_rest;
            r_last_of_tick <= last_slot;
        end
    end

    assign o_valid        = r_valid;
    assign o_servo_index  = r_servo_index;
    assign o_pulse_us     = r_pulse_us;
    assign o_angle_now    = r_angle_now;
    assign o_at_rest      = r_at_rest;
    assign o_last_of_tick = r_last_of_tick;

endmodule

// ----- hdl/msl_checker.sv -----
`include "multi_servo_slew_limiter_assert.svh"

module msl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_valid,
    input logic [2:0]  o_servo_index,
    input logic [10:0] o_pulse_us,
    input logic        o_last_of_tick
);

    // a beat only follows a cycle of work
    `MSL_ASSERT(a_beat_after_busy, o_valid |-> $past(o_busy))

    // the final beat of a tick coincides with the block going idle
    `MSL_ASSERT(a_last_frees_block, (o_valid && o_last_of_tick) |-> !o_busy)

    // within a tick, a beat is followed by a gap and then the beat of the next slot number
    `MSL_ASSERT(a_next_slot,
        (o_valid && !o_last_of_tick) |=> (!o_valid ##1
            (o_valid && (o_servo_index == $past(o_servo_index, 2) + 3'd1))))

    // pulse stays in the servo range
    `MSL_ASSERT(a_pulse_range, o_valid |-> (o_pulse_us >= 11'd400 && o_pulse_us <= 11'd2000))

endmodule

bind multi_servo_slew_limiter msl_checker u_msl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_servo_index  (o_servo_index),
    .o_pulse_us     (o_pulse_us),
    .o_last_of_tick (o_last_of_tick)
);

// ----- test/tb_multi_servo_slew_limiter.sv -----
module tb_multi_servo_slew_limiter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 8;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat at all before giving up
    localparam int DRAIN_WAIT  = 20;     // quiet cycles at the end to catch stray beats

    // one pulse report as the block emits it
    typedef struct packed {
        logic [2:0]  slot;
        logic [10:0] pulse;
        logic [7:0]  angle;
        logic        rest;
        logic        last;
    } t_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_action;
    logic [2:0]  i_slot;
    logic [7:0]  i_target_angle;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [7:0]  i_cfg_data;
    logic        o_valid;
    logic [2:0]  o_servo_index;
    logic [10:0] o_pulse_us;
    logic [7:0]  o_angle_now;
    logic        o_at_rest;
    logic        o_last_of_tick;

    multi_servo_slew_limiter #(.SERVO_SLOTS(SLOTS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_slot         (i_slot),
        .i_target_angle (i_target_angle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_servo_index  (o_servo_index),
        .o_pulse_us     (o_pulse_us),
        .o_angle_now    (o_angle_now),
        .o_at_rest      (o_at_rest),
        .o_last_of_tick (o_last_of_tick)
    );

    // mirror of the servo bank and its settings
    msl_pkg::t_slot_state m_bank [SLOTS];
    logic [3:0]           m_servos;
    msl_pkg::t_move_cfg   m_move;

    // pulse reports still owed by the block, oldest first
    t_report     due_reports [$];
    t_report     seen;
    int          errors;
    int          stall_cycles;
    bit          steady;         // set to suppress sender gaps

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // bank update for one accepted command, queues the reports it causes
    task automatic advance_servo_bank(input logic act, input logic [2:0] slot,
                                      input logic [7:0] tgt);
        int   n;
        int   span;
        int   pulse;
        logic up;
        msl_pkg::t_dir way;
        t_report r;
        n = (m_servos > SLOTS) ? SLOTS : int'(m_servos);
        if (act == msl_pkg::ACT_SET_TARGET) begin
            // slots outside the active range ignore new targets
            if (slot < n) begin
                m_bank[slot].target  = (tgt > msl_pkg::ANGLE_MAX) ? msl_pkg::ANGLE_MAX : tgt;
                m_bank[slot].pending = 1'b1;
            end
        end else begin
            for (int s = 0; s < n; s++) begin
                // pulse width comes from the angle before this tick moves it
                pulse = int'(msl_pkg::PULSE_BASE) + (80 * int'(m_bank[s].angle)) / 9;
                if (m_bank[s].hold != 8'd0) begin
                    m_bank[s].hold = m_bank[s].hold - 8'd1;
                end else if (m_bank[s].pending && m_move.retarget_hold != 8'd0) begin
                    // new target: wait before moving, flag consumed only here
                    m_bank[s].hold    = m_move.retarget_hold;
                    m_bank[s].pending = 1'b0;
                end else if (m_bank[s].angle != m_bank[s].target) begin
                    up   = m_bank[s].target > m_bank[s].angle;
                    span = up ? int'(m_bank[s].target) - int'(m_bank[s].angle)
                              : int'(m_bank[s].angle) - int'(m_bank[s].target);
                    way  = up ? msl_pkg::DIR_UP : msl_pkg::DIR_DOWN;
                    if (way != m_bank[s].dir && m_move.reverse_hold != 8'd0) begin
                        // direction change costs a hold instead of a step
                        m_bank[s].hold = m_move.reverse_hold;
                    end else begin
                        // step never overshoots; zero step leaves the angle alone
                        if (span <= int'(m_move.max_step))
                            m_bank[s].angle = m_bank[s].target;
                        else if (up)
                            m_bank[s].angle = m_bank[s].angle + m_move.max_step;
                        else
                            m_bank[s].angle = m_bank[s].angle - m_move.max_step;
                        m_bank[s].hold = m_move.move_hold;
                    end
                    m_bank[s].dir = way;
                end
                r.slot  = 3'(s);
                r.pulse = 11'(pulse);
                r.angle = m_bank[s].angle;
                r.rest  = (m_bank[s].hold == 8'd0) && (m_bank[s].angle == m_bank[s].target);
                r.last  = (s + 1 == n);
                due_reports.push_back(r);
            end
        end
    endtask

    // one command beat, with random idle cycles before it unless steady is set
    task automatic issue_cmd(input logic act, input logic [2:0] slot, input logic [7:0] tgt);
        while (!steady && $urandom_range(0, 99) < 21) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        // start stays high across back-to-back beats
        i_start        <= 1'b1;
        i_action       <= act;
        i_slot         <= slot;
        i_target_angle <= tgt;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        advance_servo_bank(act, slot, tgt);
    endtask

    task automatic tick();
        issue_cmd(msl_pkg::ACT_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic aim(input logic [2:0] slot, input logic [7:0] tgt);
        issue_cmd(msl_pkg::ACT_SET_TARGET, slot, tgt);
    endtask

    // wait for all reports, then cover a trailing set target that reports nothing
    task automatic settle_block();
        i_start <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            msl_pkg::CFG_SERVOS_IN_USE: m_servos             = data[3:0];
            msl_pkg::CFG_MAX_STEP:      m_move.max_step      = data;
            msl_pkg::CFG_MOVE_HOLD:     m_move.move_hold     = data;
            msl_pkg::CFG_REVERSE_HOLD:  m_move.reverse_hold  = data;
            msl_pkg::CFG_RETARGET_HOLD: m_move.retarget_hold = data;
            default: ;
        endcase
    endtask

    // full register set, only ever written with the block quiet
    task automatic apply_setting(input logic [7:0] servos, input logic [7:0] step,
                                 input logic [7:0] mv, input logic [7:0] rv,
                                 input logic [7:0] rt);
        settle_block();
        write_reg(msl_pkg::CFG_SERVOS_IN_USE, servos);
        write_reg(msl_pkg::CFG_MAX_STEP, step);
        write_reg(msl_pkg::CFG_MOVE_HOLD, mv);
        write_reg(msl_pkg::CFG_REVERSE_HOLD, rv);
        write_reg(msl_pkg::CFG_RETARGET_HOLD, rt);
        i_cfg_we <= 1'b0;
    endtask

    // reset settings: one slot, counting down its initial hold
    task automatic test_defaults();
        aim(3'd0, 8'd255);       // saturates at the angle limit
        aim(3'd5, 8'd50);        // slot not in use, dropped
        tick();
        tick();
    endtask

    // all slots, full-range step, no holds configured
    task automatic test_slot_extremes();
        apply_setting(8'd8, 8'd180, 8'd0, 8'd0, 8'd0);
        aim(3'd7, 8'd200);
        aim(3'd0, 8'd0);
        aim(3'd3, 8'd180);
        // drain the reset hold, jump to full scale, then report the top pulse
        repeat (12) tick();
    endtask

    // retarget hold, reversal hold from rest and a zero-size step
    task automatic test_hold_paths();
        apply_setting(8'd2, 8'd0, 8'd1, 8'd1, 8'd1);
        aim(3'd1, 8'd100);
        repeat (5) tick();
    endtask

    // no slots in use, then a count above the slot array
    task automatic test_slot_count_limits();
        apply_setting(8'd0, 8'd5, 8'd0, 8'd0, 8'd0);
        tick();                  // no reports at all
        aim(3'd0, 8'd90);        // ignored with no slots
        apply_setting(8'hFF, 8'd5, 8'd0, 8'd0, 8'd0);
        tick();                  // acts as the full eight slots
    endtask

    // mostly valid targets on slots in use mixed with ticks, some stray targets
    task automatic test_random_traffic();
        int n;
        int done;
        int roll;
        logic [7:0] tgt;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: apply_setting(8'd8, 8'd1, 8'd0, 8'd0, 8'd0);
                5: apply_setting(8'd8, 8'd180, 8'd255, 8'd255, 8'd255);
                default: apply_setting(8'($urandom_range(1, 8)),
                                       ($urandom_range(0, 1) != 0) ?
                                           8'($urandom_range(1, 20)) :
                                           8'($urandom_range(1, 180)),
                                       8'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 4)),
                                       8'($urandom_range(0, 4)));
            endcase
            steady = (p == 2);   // one phase at full command rate
            n      = (m_servos > SLOTS) ? SLOTS : int'(m_servos);
            done   = 0;
            while (done < 30) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 2) == 0)
                    tgt = ($urandom_range(0, 1) != 0) ? msl_pkg::ANGLE_MAX
                                                      : 8'($urandom_range(181, 255));
                else
                    tgt = 8'($urandom_range(0, 255));
                if (roll < 55) begin
                    tick();
                    done++;
                end else if (roll < 90) begin
                    aim(3'($urandom_range(0, n - 1)), tgt);
                    done++;
                end else begin
                    // stray slot: counts only when it lands on a live slot
                    roll = $urandom_range(0, 7);
                    aim(3'(roll), tgt);
                    if (roll < n) done++;
                end
            end
        end
        steady = 1'b0;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // every report beat is taken at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual slot %0d pulse %0d",
                         $time, o_servo_index, o_pulse_us);
                errors++;
            end else begin
                seen = due_reports.pop_front();
                check_field("servo_index", seen.slot, o_servo_index);
                check_field("pulse_us", seen.pulse, o_pulse_us);
                check_field("angle_now", seen.angle, o_angle_now);
                check_field("at_rest", seen.rest, o_at_rest);
                check_field("last_of_tick", seen.last, o_last_of_tick);
            end
        end
    end

    // watchdog on cycles with no beat on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || i_cfg_we || (i_start && !o_busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        steady         = 1'b0;
        i_rst_n        <= 1'b0;
        i_start        <= 1'b0;
        i_action       <= msl_pkg::ACT_TICK;
        i_slot         <= 3'd0;
        i_target_angle <= 8'd0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= msl_pkg::CFG_SERVOS_IN_USE;
        i_cfg_data     <= 8'd0;

        // mirror starts from the reset state
        foreach (m_bank[i]) m_bank[i] = msl_pkg::SLOT_RESET;
        m_servos             = 4'd1;
        m_move.max_step      = 8'd1;
        m_move.move_hold     = 8'd10;
        m_move.reverse_hold  = 8'd0;
        m_move.retarget_hold = 8'd0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_slot_extremes();
        test_hold_paths();
        test_slot_count_limits();
        test_random_traffic();

        settle_block();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
